// File: rtl/assert_macros.svh
// Assertion macros shared by the encoder unwrap RTL.
// Each macro checks on the rising clock and holds off during synchronous reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every clock edge.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Check that cons holds in the same cycle as ante.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/eturn_pkg.sv
// Shared types and constants for the encoder turn unwrap block.
// No dependencies; used by every module under rtl.
`timescale 1ns / 1ps

package eturn_pkg;

  localparam int COUNTS_PER_TURN_DEF = 8192;
  localparam int MAX_RATIO_DEF       = 64;

  localparam int ANGLE_W = 13;
  localparam int THR_W   = 13;
  localparam int RATIO_W = 7;
  localparam int OUT_W   = 15;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [OUT_W-1:0]   SAT_MAX       = 15'h7fff;
  localparam logic [THR_W-1:0]   THR_RESET     = 13'd6992;
  localparam logic [RATIO_W-1:0] RATIO_RESET   = 7'd1;
  localparam logic [RATIO_W-1:0] RATIO_HALVE   = 7'd2;

  typedef enum logic [1:0] {
    REG_WRAP_THRESHOLD = 2'd0,
    REG_GEAR_RATIO     = 2'd1,
    REG_OUTPUT_MODE    = 2'd2,
    REG_UNUSED         = 2'd3
  } reg_idx_t;

  typedef enum logic {
    MODE_DIVIDE = 1'b0,
    MODE_HALVE  = 1'b1
  } out_mode_t;

  typedef struct packed {
    logic start;
    logic div_step;
    logic emit;
  } eturn_cmd_t;

  typedef struct packed {
    logic div_last;
  } eturn_status_t;

endpackage

// File: rtl/eturn_dp.sv
// Datapath: turn tracking, extended angle, serial restoring divider, result register.
// Depends on eturn_pkg and assert_macros.svh; driven by eturn_ctrl commands.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module eturn_dp #(
  parameter int COUNTS_PER_TURN = eturn_pkg::COUNTS_PER_TURN_DEF,
  parameter int MAX_RATIO       = eturn_pkg::MAX_RATIO_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  eturn_pkg::eturn_cmd_t              cmd,
  output eturn_pkg::eturn_status_t           status,
  input  logic [eturn_pkg::ANGLE_W-1:0]      in_raw_angle,
  input  logic                               in_started,
  input  logic [eturn_pkg::THR_W-1:0]        wrap_threshold,
  input  logic [eturn_pkg::RATIO_W-1:0]      gear_ratio,
  input  eturn_pkg::out_mode_t               output_mode,
  output logic [eturn_pkg::OUT_W-1:0]        out_scaled_angle
);
  import eturn_pkg::*;

  localparam int TW   = (MAX_RATIO > 1) ? $clog2(MAX_RATIO) : 1;
  localparam int EW   = $clog2((1 << ANGLE_W) + COUNTS_PER_TURN * (MAX_RATIO - 1));
  localparam int CNTW = $clog2(EW);
  localparam int CMPW = ((TW > RATIO_W) ? TW : RATIO_W) + 1;
  localparam int SW   = (EW > OUT_W) ? EW : OUT_W;

  logic [ANGLE_W-1:0] prev_r, prev_nxt;
  logic [TW-1:0]      turn_r, turn_nxt, turn_upd;
  logic [EW-1:0]      quo_r, quo_nxt;
  logic [RATIO_W-1:0] rem_r, rem_nxt;
  logic [RATIO_W-1:0] div_r, div_nxt;
  logic [CNTW-1:0]    cnt_r, cnt_nxt;
  logic [OUT_W-1:0]   res_r, res_nxt;

  logic [RATIO_W-1:0] ratio;
  logic [ANGLE_W:0]   raw_plus_thr, prev_plus_thr;
  logic               fwd, back;
  logic [CMPW-1:0]    t_inc;
  logic               wrap_up, turn_hi;
  logic [EW-1:0]      ext;
  logic [RATIO_W:0]   shifted;
  logic               ge;
  logic [SW-1:0]      quo_ext;

  always_comb begin
    ratio = gear_ratio;
    if (gear_ratio == '0) begin
      ratio = RATIO_W'(1);
    end else if (int'(gear_ratio) > MAX_RATIO) begin
      ratio = RATIO_W'(MAX_RATIO);
    end
  end

  always_comb begin
    raw_plus_thr  = {1'b0, in_raw_angle} + {1'b0, wrap_threshold};
    prev_plus_thr = {1'b0, prev_r} + {1'b0, wrap_threshold};
    fwd     = raw_plus_thr < {1'b0, prev_r};
    back    = {1'b0, in_raw_angle} > prev_plus_thr;
    t_inc   = CMPW'(turn_r) + CMPW'(1);
    wrap_up = t_inc >= CMPW'(ratio);
    turn_hi = CMPW'(turn_r) >= CMPW'(ratio);
    turn_upd = turn_r;
    if (fwd) begin
      turn_upd = wrap_up ? '0 : t_inc[TW-1:0];
    end else if (back) begin
      turn_upd = ((turn_r == '0) || turn_hi) ? TW'(ratio - RATIO_W'(1)) : turn_r - TW'(1);
    end
    if (in_started) begin
      ext = EW'(in_raw_angle) + EW'(turn_upd) * EW'(COUNTS_PER_TURN);
    end else begin
      ext = EW'(in_raw_angle);
    end
  end

  always_comb begin
    shifted = {rem_r, quo_r[EW-1]};
    ge      = shifted >= {1'b0, div_r};
    quo_ext = SW'(quo_r);
  end

  always_comb begin
    prev_nxt = prev_r;
    turn_nxt = turn_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    res_nxt  = res_r;
    if (cmd.start) begin
      prev_nxt = in_raw_angle;
      if (in_started) begin
        turn_nxt = turn_upd;
      end
      quo_nxt = ext;
      rem_nxt = '0;
      div_nxt = (output_mode == MODE_HALVE) ? RATIO_HALVE : ratio;
      cnt_nxt = CNTW'(EW - 1);
    end else if (cmd.div_step) begin
      rem_nxt = ge ? RATIO_W'(shifted - {1'b0, div_r}) : shifted[RATIO_W-1:0];
      quo_nxt = {quo_r[EW-2:0], ge};
      cnt_nxt = cnt_r - CNTW'(1);
    end
    if (cmd.emit) begin
      res_nxt = (quo_ext > SW'(SAT_MAX)) ? SAT_MAX : quo_ext[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      turn_r <= '0;
    end else begin
      prev_r <= prev_nxt;
      turn_r <= turn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    cnt_r <= cnt_nxt;
    res_r <= res_nxt;
  end

  assign status.div_last  = (cnt_r == '0);
  assign out_scaled_angle = res_r;

  `ASSERT_SAME(a_rem_below_div, clk, rst_n, cmd.div_step, rem_r < div_r, "remainder not below divisor")
  `ASSERT_NEXT(a_turn_hold_idle, clk, rst_n, cmd.start && !in_started, $stable(turn_r), "turn count moved while not started")

endmodule

// File: rtl/eturn_ctrl.sv
// Controller: sequences accept, divide and emit for one item at a time.
// Depends on eturn_pkg and assert_macros.svh; commands eturn_dp.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module eturn_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  logic                     out_stall,
  output eturn_pkg::eturn_cmd_t    cmd,
  input  eturn_pkg::eturn_status_t status
);
  import eturn_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt    = state_r;
    cmd.start    = 1'b0;
    cmd.div_step = 1'b0;
    cmd.emit     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  `ASSERT_NEXT(a_accept_to_div, clk, rst_n, in_valid && !in_stall, state_r == S_DIV, "accept did not start divide")
  `ASSERT_NEXT(a_div_to_done, clk, rst_n, (state_r == S_DIV) && status.div_last, state_r == S_DONE, "divide did not finish")
  `ASSERT_SAME(a_valid_from_done, clk, rst_n, $rose(out_valid_r), $past(state_r == S_DONE), "result raised outside done")

endmodule

// File: rtl/encoder_turn_unwrap_gear_scale.sv
// Top level of the multi-turn encoder unwrap with gear scaling.
// Holds the configuration registers; instantiates eturn_ctrl and eturn_dp, using types from eturn_pkg.
//
//   port group   direction   handshake            payload
//   in_          input       in_valid/in_stall    in_raw_angle, in_started
//   out_         output      out_valid/out_stall  out_scaled_angle
//   p*           config      psel/penable/pready  paddr, pwdata, prdata
//
// Each item is accepted and unwrapped, then divided by the serial divider, one quotient
// bit a cycle over EW bits, EW being the extended angle width (19 at the defaults), then
// loaded into the result register; only then is the next item accepted.
// Reset clears the previous angle, the turn count and the registers to their defaults.
// A held result does not block the next accept; a new result waits in the controller.
`timescale 1ns / 1ps

module encoder_turn_unwrap_gear_scale #(
  parameter int COUNTS_PER_TURN = eturn_pkg::COUNTS_PER_TURN_DEF,
  parameter int MAX_RATIO       = eturn_pkg::MAX_RATIO_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [eturn_pkg::ANGLE_W-1:0]  in_raw_angle,
  input  logic                           in_started,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [eturn_pkg::OUT_W-1:0]    out_scaled_angle,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [eturn_pkg::ADDR_W-1:0]   paddr,
  input  logic [eturn_pkg::DATA_W-1:0]   pwdata,
  output logic [eturn_pkg::DATA_W-1:0]   prdata,
  output logic                           pready
);
  import eturn_pkg::*;

  logic [THR_W-1:0]   wrap_threshold_r, wrap_threshold_nxt;
  logic [RATIO_W-1:0] gear_ratio_r, gear_ratio_nxt;
  out_mode_t          output_mode_r, output_mode_nxt;
  reg_idx_t           reg_idx;
  logic               cfg_wr;
  eturn_cmd_t         cmd;
  eturn_status_t      status;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    wrap_threshold_nxt = wrap_threshold_r;
    gear_ratio_nxt     = gear_ratio_r;
    output_mode_nxt    = output_mode_r;
    if (cfg_wr) begin
      case (reg_idx)
        REG_WRAP_THRESHOLD: wrap_threshold_nxt = pwdata[THR_W-1:0];
        REG_GEAR_RATIO:     gear_ratio_nxt     = pwdata[RATIO_W-1:0];
        REG_OUTPUT_MODE:    output_mode_nxt    = out_mode_t'(pwdata[0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WRAP_THRESHOLD: prdata = DATA_W'(wrap_threshold_r);
      REG_GEAR_RATIO:     prdata = DATA_W'(gear_ratio_r);
      REG_OUTPUT_MODE:    prdata = DATA_W'(output_mode_r);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_threshold_r <= THR_RESET;
      gear_ratio_r     <= RATIO_RESET;
      output_mode_r    <= MODE_DIVIDE;
    end else begin
      wrap_threshold_r <= wrap_threshold_nxt;
      gear_ratio_r     <= gear_ratio_nxt;
      output_mode_r    <= output_mode_nxt;
    end
  end

  eturn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  eturn_dp #(
    .COUNTS_PER_TURN (COUNTS_PER_TURN),
    .MAX_RATIO       (MAX_RATIO)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_raw_angle     (in_raw_angle),
    .in_started       (in_started),
    .wrap_threshold   (wrap_threshold_r),
    .gear_ratio       (gear_ratio_r),
    .output_mode      (output_mode_r),
    .out_scaled_angle (out_scaled_angle)
  );

endmodule
